/* design/strq_pkg.sv */
// ----------------------------------------------------------------------------
// Sparse table range min/max query: shared types and constants
// Mode codes, status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package strq_pkg;

   localparam int DEPTH_DEF      = 1024;
   localparam int LEVELS_DEF     = 11;
   localparam int VALUE_BITS_DEF = 32;

   localparam int POS_BITS  = 10;
   localparam int DATA_BITS = 32;

   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_QUERY   = 2'd1,
      MODE_RESTART = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_BAD  = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_RD,     // issue read of level k-1 at p-half (read at p follows)
      ST_LD_WAIT,   // table data arriving
      ST_LD_VRD,    // issue value reads of the two candidates
      ST_LD_VWAIT,
      ST_LD_WR,     // write level k with the compared winners
      ST_Q_RD,
      ST_Q_WAIT,
      ST_Q_VRD,
      ST_Q_VWAIT,
      ST_Q_CMP,
      ST_OUT
   } state_type;

endpackage

/* design/sparse_table_range_min_max_query_top.sv */
// ----------------------------------------------------------------------------
// Sparse table range min/max query, top level
// Growing value array with sparse tables of min and max positions.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------
//  req     | in  | req_tvalid/tready  | mode, value, left, right, excluded
//  rsp     | out | rsp_tvalid/tready  | found, position, status
//
// A load is accepted, then for each level updated reads two table entries,
// the values of the min and then the max candidates, and writes one entry;
// a final level check and output end it. A query reads two table entries
// and values, then compares; one read port per memory forces the steps.
// Restart and rejects go straight to output; mode 3 is dropped silently.
// Reset clears the fill count and the sequencer; the memories are not
// cleared. The result waits in the rsp register; a stall there holds the
// sequencer in its output state and req_tready stays low.
//
module sparse_table_range_min_max_query_top #(
   parameter int DEPTH      = strq_pkg::DEPTH_DEF,
   parameter int LEVELS     = strq_pkg::LEVELS_DEF,
   parameter int VALUE_BITS = strq_pkg::VALUE_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [1:0] mode, [33:2] value, [43:34] left, [53:44] right,
   // [85:54] excluded, [87:86] zero fill
   input  logic [87:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [0] found, [10:1] position, [12:11] status, [15:13] zero fill
   output logic [15:0]   rsp_tdata
);

   localparam int AW  = $clog2(DEPTH);
   localparam int LW  = $clog2(LEVELS + 1);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int PB  = strq_pkg::POS_BITS;
   localparam int DB  = strq_pkg::DATA_BITS;
   localparam int TAW = $clog2(LEVELS * DEPTH);

   // request fields
   logic [1:0]    req_mode;
   logic [DB-1:0] req_value, req_excluded;
   logic [PB-1:0] req_left, req_right;
   assign req_mode     = req_tdata[1:0];
   assign req_value    = req_tdata[33:2];
   assign req_left     = req_tdata[43:34];
   assign req_right    = req_tdata[53:44];
   assign req_excluded = req_tdata[85:54];

   // sign-extended value, top bit flipped so unsigned compare orders it
   function automatic logic [VALUE_BITS-1:0] to_key(input logic [DB-1:0] raw);
      logic [VALUE_BITS-1:0] v;
      begin
         v = VALUE_BITS'($signed(raw));
         v[VALUE_BITS-1] = ~v[VALUE_BITS-1];
         return v;
      end
   endfunction

   strq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         p_ff, p_in;          // load position
   logic [LW-1:0]         k_ff, k_in;          // level
   logic [AW-1:0]         a_ff, a_in;          // first window end
   logic [AW-1:0]         b_ff, b_in;          // second window end
   logic [VALUE_BITS-1:0] ex_ff, ex_in;
   logic [AW-1:0]         mn0_ff, mn0_in, mx0_ff, mx0_in; // first candidates
   logic [AW-1:0]         mn1_ff, mn1_in, mx1_ff, mx1_in; // second candidates
   logic [VALUE_BITS-1:0] vmn0_ff, vmn0_in, vmx0_ff, vmx0_in;
   logic                  phase_ff, phase_in;  // table and value read sub-step
   logic                  found_ff, found_in;
   logic [PB-1:0]         pos_ff, pos_in;
   logic [1:0]            stat_ff, stat_in;

   // memories: values (two copies for two reads), min table, max table
   logic                  v_we;
   logic [AW-1:0]         v_wa, va_ra, vb_ra;
   logic [VALUE_BITS-1:0] v_wd, va_rd, vb_rd;
   logic                  t_we;
   logic [TAW-1:0]        t_wa, t_ra0;
   logic [AW-1:0]         mn_wd, mx_wd, mn_rd, mx_rd;

   strq_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_val_a (
      .clock, .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(va_ra), .rd_data(va_rd));
   strq_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_val_b (
      .clock, .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(vb_ra), .rd_data(vb_rd));
   strq_ram #(.WIDTH(AW), .DEPTH(LEVELS * DEPTH)) u_min_tab (
      .clock, .wr_en(t_we), .wr_addr(t_wa), .wr_data(mn_wd),
      .rd_addr(t_ra0), .rd_data(mn_rd));
   strq_ram #(.WIDTH(AW), .DEPTH(LEVELS * DEPTH)) u_max_tab (
      .clock, .wr_en(t_we), .wr_addr(t_wa), .wr_data(mx_wd),
      .rd_addr(t_ra0), .rd_data(mx_rd));

   function automatic logic [TAW-1:0] tidx(input logic [LW-1:0] lv,
                                           input logic [AW-1:0] e);
      begin
         return TAW'(lv * DEPTH) + TAW'(e);
      end
   endfunction

   // query level: floor(log2(len)) saturated at LEVELS-1 (priority encode)
   logic [PB:0]   q_len;
   logic [LW-1:0] q_k;
   always_comb begin
      q_len = {1'b0, req_right} - {1'b0, req_left} + 1'b1;
      q_k   = '0;
      for (int i = 1; i <= PB; i++) begin
         if (q_len[i]) q_k = (i < LEVELS) ? LW'(i) : LW'(LEVELS - 1);
      end
   end

   logic [AW:0] half_sum;   // p+1 compared against 2^k
   logic        q_bad;
   assign q_bad = (req_left > req_right) || (CW'(req_right) >= count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      p_in = p_ff; k_in = k_ff; a_in = a_ff; b_in = b_ff; ex_in = ex_ff;
      mn0_in = mn0_ff; mn1_in = mn1_ff; mx0_in = mx0_ff; mx1_in = mx1_ff;
      vmn0_in = vmn0_ff; vmx0_in = vmx0_ff; phase_in = phase_ff;
      found_in = found_ff; pos_in = pos_ff; stat_in = stat_ff;
      req_tready = 1'b0;
      v_we = 1'b0; v_wa = p_ff; v_wd = ex_ff;
      va_ra = mn0_ff; vb_ra = mn1_ff;
      t_we = 1'b0; t_wa = tidx(k_ff, p_ff); mn_wd = mn1_ff; mx_wd = mx1_ff;
      t_ra0 = tidx(k_ff, a_ff);
      half_sum = '0;

      case (state_ff)
         strq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               found_in = 1'b0; pos_in = '0; stat_in = strq_pkg::STAT_OK;
               case (req_mode)
                  strq_pkg::MODE_LOAD: begin
                     if (count_ff >= CW'(DEPTH)) begin
                        stat_in  = strq_pkg::STAT_FULL;
                        state_in = strq_pkg::ST_OUT;
                     end else begin
                        p_in = AW'(count_ff);
                        v_we = 1'b1; v_wa = AW'(count_ff);
                        v_wd = to_key(req_value);
                        t_we = 1'b1; t_wa = tidx('0, AW'(count_ff));
                        mn_wd = AW'(count_ff); mx_wd = AW'(count_ff);
                        count_in = count_ff + 1'b1;
                        k_in = LW'(1);
                        state_in = strq_pkg::ST_LD_RD;
                     end
                  end
                  strq_pkg::MODE_QUERY: begin
                     if (q_bad) begin
                        stat_in  = strq_pkg::STAT_BAD;
                        state_in = strq_pkg::ST_OUT;
                     end else begin
                        k_in = q_k;
                        a_in = AW'(req_left) + AW'((1 << q_k) - 1);
                        b_in = AW'(req_right);
                        ex_in = to_key(req_excluded);
                        phase_in = 1'b0;
                        state_in = strq_pkg::ST_Q_RD;
                     end
                  end
                  strq_pkg::MODE_RESTART: begin
                     count_in = '0;
                     state_in = strq_pkg::ST_OUT;
                  end
                  default: ;
               endcase
            end
         end

         // load: level k entry at p from level k-1 at p-half and p
         strq_pkg::ST_LD_RD: begin
            half_sum = {1'b0, p_ff} + 1'b1;
            if (k_ff >= LW'(LEVELS) || ((AW+1)'(1) << k_ff) > half_sum) begin
               state_in = strq_pkg::ST_OUT;
            end else begin
               t_ra0 = tidx(k_ff - 1'b1, p_ff - AW'((1 << k_ff) >> 1));
               phase_in = 1'b0;
               state_in = strq_pkg::ST_LD_WAIT;
            end
         end
         strq_pkg::ST_LD_WAIT: begin
            // first data arrives now; issue second read
            if (!phase_ff) begin
               mn0_in = mn_rd; mx0_in = mx_rd;
               t_ra0 = tidx(k_ff - 1'b1, p_ff);
               phase_in = 1'b1;
            end else begin
               mn1_in = mn_rd; mx1_in = mx_rd;
               state_in = strq_pkg::ST_LD_VRD;
            end
         end
         strq_pkg::ST_LD_VRD, strq_pkg::ST_Q_VRD: begin
            va_ra = mn0_ff; vb_ra = mn1_ff;
            phase_in = 1'b0;
            state_in = (state_ff == strq_pkg::ST_LD_VRD) ?
                       strq_pkg::ST_LD_VWAIT : strq_pkg::ST_Q_VWAIT;
         end
         strq_pkg::ST_LD_VWAIT, strq_pkg::ST_Q_VWAIT: begin
            if (!phase_ff) begin
               vmn0_in = va_rd; vmx0_in = vb_rd;  // min pair values held
               va_ra = mx0_ff; vb_ra = mx1_ff;
               phase_in = 1'b1;
            end else begin
               // vmn0=val(mn0) vmx0=val(mn1); va_rd=val(mx0) vb_rd=val(mx1)
               mn0_in = (vmn0_ff < vmx0_ff) ? mn0_ff : mn1_ff;
               mx0_in = (va_rd > vb_rd) ? mx0_ff : mx1_ff;
               vmn0_in = (vmn0_ff < vmx0_ff) ? vmn0_ff : vmx0_ff;
               vmx0_in = (va_rd > vb_rd) ? va_rd : vb_rd;
               state_in = (state_ff == strq_pkg::ST_LD_VWAIT) ?
                          strq_pkg::ST_LD_WR : strq_pkg::ST_Q_CMP;
            end
         end
         strq_pkg::ST_LD_WR: begin
            t_we = 1'b1; t_wa = tidx(k_ff, p_ff);
            mn_wd = mn0_ff; mx_wd = mx0_ff;
            k_in = k_ff + 1'b1;
            state_in = strq_pkg::ST_LD_RD;
         end

         // query: entries at (k, a) and (k, b)
         strq_pkg::ST_Q_RD: begin
            t_ra0 = tidx(k_ff, a_ff);
            phase_in = 1'b0;
            state_in = strq_pkg::ST_Q_WAIT;
         end
         strq_pkg::ST_Q_WAIT: begin
            if (!phase_ff) begin
               mn0_in = mn_rd; mx0_in = mx_rd;
               t_ra0 = tidx(k_ff, b_ff);
               phase_in = 1'b1;
            end else begin
               mn1_in = mn_rd; mx1_in = mx_rd;
               state_in = strq_pkg::ST_Q_VRD;
            end
         end
         strq_pkg::ST_Q_CMP: begin
            if (vmn0_ff != ex_ff) begin
               found_in = 1'b1; pos_in = PB'(mn0_ff);
            end else if (vmn0_ff != vmx0_ff) begin
               found_in = 1'b1; pos_in = PB'(mx0_ff);
            end
            state_in = strq_pkg::ST_OUT;
         end
         strq_pkg::ST_OUT: begin
            if (rsp_tready) state_in = strq_pkg::ST_IDLE;
         end
         default: state_in = strq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= strq_pkg::ST_IDLE;
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
      p_ff <= p_in; k_ff <= k_in; a_ff <= a_in; b_ff <= b_in; ex_ff <= ex_in;
      mn0_ff <= mn0_in; mn1_ff <= mn1_in; mx0_ff <= mx0_in; mx1_ff <= mx1_in;
      vmn0_ff <= vmn0_in; vmx0_ff <= vmx0_in;
      found_ff <= found_in; pos_ff <= pos_in; stat_ff <= stat_in;
   end

   assign rsp_tvalid = (state_ff == strq_pkg::ST_OUT);
   assign rsp_tdata  = {3'b000, stat_ff, pos_ff, found_ff};

endmodule

/* design/strq_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module strq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
